// ===== hdl/lfr_pkg.sv =====
// lfr_pkg: shared types and constants of the lcd frame buffer refresh block
// used by the interfaces' users, the controller, the datapath and the top level
// no dependencies

package lfr_pkg;

    // default geometry of the frame store
    localparam int PAGE_COUNT_DEF    = 8;
    localparam int STORE_COLUMNS_DEF = 132;

    // panel command bytes sent ahead of every page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam int         CMD_BYTES     = 3;

    // column offset register
    localparam int         OFFSET_W     = 3;
    localparam logic [2:0] OFFSET_RESET = 3'd4;

    // operation codes of an item
    typedef enum logic [1:0] {
        OP_WRITE_PIXEL = 2'd0,
        OP_CLEAR       = 2'd1,
        OP_START       = 2'd2,
        OP_TICK        = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_RMW,
        ST_TICK
    } state_t;

    // kind of result loaded into the output register
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PLAIN,
        EMIT_TICK
    } emit_t;

    // controller to datapath
    typedef struct packed {
        logic  in_ready;
        logic  sweep_write;
        logic  pix_read;
        logic  pix_write;
        logic  tick_read;
        logic  start_refresh;
        emit_t emit;
    } lfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic pixel_in_range;
        logic running;
        logic tick_data;
        logic sweep_last;
        logic out_empty;
    } lfr_status_t;

endpackage

// ===== hdl/lfr_in_if.sv =====
// lfr_in_if: request channel of the lcd frame buffer refresh block
// valid/ready handshake with the item fields; no dependencies

interface lfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] row;
    logic [6:0] column;
    logic       pixel_value;

    modport source (output valid, output operation, output row, output column,
                    output pixel_value, input ready);
    modport sink (input valid, input operation, input row, input column,
                  input pixel_value, output ready);
endinterface

// ===== hdl/lfr_out_if.sv =====
// lfr_out_if: result channel of the lcd frame buffer refresh block
// valid/ready handshake with the result fields; no dependencies

interface lfr_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] serial_byte;
    logic       data_mode;
    logic       select_active;
    logic       refresh_done;
    logic       busy_res;

    modport source (output valid, output byte_valid, output serial_byte,
                    output data_mode, output select_active, output refresh_done,
                    output busy_res, input ready);
    modport sink (input valid, input byte_valid, input serial_byte,
                  input data_mode, input select_active, input refresh_done,
                  input busy_res, output ready);
endinterface

// ===== hdl/lfr_ram.sv =====
// lfr_ram: generic single write port, single read port ram with registered read
// no dependencies

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1056
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lfr_datapath.sv =====
// lfr_datapath: item latch, column offset register, frame store, refresh counters
// and output register; depends on lfr_pkg and lfr_ram

module lfr_datapath #(
    parameter int PAGE_COUNT    = lfr_pkg::PAGE_COUNT_DEF,
    parameter int STORE_COLUMNS = lfr_pkg::STORE_COLUMNS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [lfr_pkg::OFFSET_W-1:0] cfg_write_data,
    input  logic                     in_valid,
    input  logic [1:0]               in_operation,
    input  logic [5:0]               in_row,
    input  logic [6:0]               in_column,
    input  logic                     in_pixel_value,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     out_byte_valid,
    output logic [7:0]               out_serial_byte,
    output logic                     out_data_mode,
    output logic                     out_select_active,
    output logic                     out_refresh_done,
    output logic                     out_busy_res,
    input  lfr_pkg::lfr_cmd_t        cmd,
    output lfr_pkg::lfr_status_t     status
);

    import lfr_pkg::*;

    localparam int DEPTH  = PAGE_COUNT * STORE_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = $clog2(PAGE_COUNT + 1);
    localparam int BYTE_W = $clog2(STORE_COLUMNS + CMD_BYTES);

    // latched item
    logic [1:0] op_reg;
    logic [5:0] row_reg;
    logic [6:0] col_reg;
    logic       pix_reg;

    logic [OFFSET_W-1:0] column_offset_reg;

    // refresh sequencer state
    logic              running_reg, running_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              done_next;

    // clearing sweep address
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic              sweep_last;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_bvalid_reg;
    logic [7:0] out_byte_reg;
    logic       out_dmode_reg;
    logic       out_select_reg;
    logic       out_done_reg;
    logic       out_busy_reg;

    // addressing
    logic [2:0]        pix_page;
    logic [7:0]        pix_col;
    logic              pix_in_range;
    logic [ADDR_W-1:0] pix_addr;
    logic [BYTE_W-1:0] ref_col;
    logic [ADDR_W-1:0] ref_addr;
    logic [7:0]        pix_mask;
    logic [7:0]        pix_byte;
    logic [7:0]        tick_byte;
    logic              tick_dmode;

    // store ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // item latch
    always_ff @(posedge clk)
    begin
        if (in_valid && cmd.in_ready)
        begin
            op_reg  <= in_operation;
            row_reg <= in_row;
            col_reg <= in_column;
            pix_reg <= in_pixel_value;
        end
    end

    // column offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= OFFSET_RESET;
        end
        else if (cfg_write_en)
        begin
            column_offset_reg <= cfg_write_data;
        end
    end

    // pixel address and range check
    assign pix_page     = row_reg[5:3];
    assign pix_col      = 8'(col_reg) + 8'(column_offset_reg);
    assign pix_in_range = (32'(pix_page) < PAGE_COUNT) && (32'(pix_col) < STORE_COLUMNS);
    assign pix_addr     = ADDR_W'(32'(pix_page) * STORE_COLUMNS + 32'(pix_col));

    // read-modify-write of one pixel bit
    assign pix_mask = 8'd1 << row_reg[2:0];
    assign pix_byte = pix_reg ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);

    // refresh address of the current data byte
    assign ref_col  = byte_reg - BYTE_W'(CMD_BYTES);
    assign ref_addr = ADDR_W'(32'(page_reg) * STORE_COLUMNS + 32'(ref_col));

    // clearing sweep
    assign sweep_last      = (sweep_addr_reg == ADDR_W'(DEPTH - 1));
    assign sweep_addr_next = sweep_last ? '0 : sweep_addr_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    // store port selection
    always_comb
    begin
        ram_wr_en   = cmd.sweep_write || cmd.pix_write;
        ram_wr_addr = cmd.sweep_write ? sweep_addr_reg : pix_addr;
        ram_wr_data = cmd.sweep_write ? 8'h00 : pix_byte;
        ram_rd_en   = cmd.pix_read || cmd.tick_read;
        ram_rd_addr = cmd.pix_read ? pix_addr : ref_addr;
    end

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // byte sent on a tick
    always_comb
    begin
        tick_dmode = 1'b0;
        priority if (byte_reg == BYTE_W'(0))
        begin
            tick_byte = CMD_PAGE_BASE | (8'(page_reg) & 8'h0F);
        end
        else if (byte_reg == BYTE_W'(1))
        begin
            tick_byte = CMD_COL_HIGH;
        end
        else if (byte_reg == BYTE_W'(2))
        begin
            tick_byte = CMD_COL_LOW;
        end
        else
        begin
            tick_byte  = ram_rd_data;
            tick_dmode = 1'b1;
        end
    end

    // refresh sequencer next state
    always_comb
    begin
        running_next = running_reg;
        page_next    = page_reg;
        byte_next    = byte_reg;
        done_next    = 1'b0;
        if (cmd.start_refresh && !running_reg)
        begin
            running_next = 1'b1;
            page_next    = '0;
            byte_next    = '0;
        end
        else if (cmd.emit == EMIT_TICK)
        begin
            if (byte_reg == BYTE_W'(STORE_COLUMNS + CMD_BYTES - 1))
            begin
                byte_next = '0;
                if (page_reg == PAGE_W'(PAGE_COUNT - 1))
                begin
                    page_next    = '0;
                    running_next = 1'b0;
                    done_next    = 1'b1;
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
            end
            else
            begin
                byte_next = byte_reg + BYTE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            page_reg    <= '0;
            byte_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            page_reg    <= page_next;
            byte_reg    <= byte_next;
        end
    end

    // output register valid
    always_comb
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit == EMIT_TICK)
        begin
            out_bvalid_reg <= 1'b1;
            out_byte_reg   <= tick_byte;
            out_dmode_reg  <= tick_dmode;
            out_select_reg <= 1'b1;
            out_done_reg   <= done_next;
            out_busy_reg   <= running_next;
        end
        else if (cmd.emit == EMIT_PLAIN)
        begin
            out_bvalid_reg <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_dmode_reg  <= 1'b0;
            out_select_reg <= running_next;
            out_done_reg   <= 1'b0;
            out_busy_reg   <= running_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte_valid    = out_bvalid_reg;
    assign out_serial_byte   = out_byte_reg;
    assign out_data_mode     = out_dmode_reg;
    assign out_select_active = out_select_reg;
    assign out_refresh_done  = out_done_reg;
    assign out_busy_res      = out_busy_reg;

    // status to the controller
    always_comb
    begin
        status.op             = op_t'(op_reg);
        status.pixel_in_range = pix_in_range;
        status.running        = running_reg;
        status.tick_data      = (byte_reg >= BYTE_W'(CMD_BYTES));
        status.sweep_last     = sweep_last;
        status.out_empty      = !out_valid_reg;
    end

    // an idle sequencer always restarts from the first page command
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (page_reg == '0) && (byte_reg == '0))
        else $error("refresh counters not cleared while idle");

    // the byte counter never runs past the last column byte
    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(byte_reg) < STORE_COLUMNS + CMD_BYTES)
        else $error("byte counter out of range");

    // a finished refresh is flagged on a data byte and leaves the block idle
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |->
            out_bvalid_reg && out_dmode_reg && !out_busy_reg)
        else $error("refresh done flag on a wrong byte");

endmodule

// ===== hdl/lfr_ctrl.sv =====
// lfr_ctrl: controller state machine of the lcd frame buffer refresh block
// depends on lfr_pkg; drives the datapath by command, reads its status

module lfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  lfr_pkg::lfr_status_t status,
    output lfr_pkg::lfr_cmd_t    cmd
);

    import lfr_pkg::*;

    state_t state_reg, state_next;
    logic   clear_reply_reg, clear_reply_next;

    // next state
    always_comb
    begin
        state_next       = state_reg;
        clear_reply_next = clear_reply_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next       = ST_IDLE;
                    clear_reply_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && status.out_empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.op)
                    OP_WRITE_PIXEL: state_next = status.pixel_in_range ? ST_RMW : ST_IDLE;
                    OP_CLEAR:
                    begin
                        state_next       = ST_SWEEP;
                        clear_reply_next = 1'b1;
                    end
                    OP_START:       state_next = ST_IDLE;
                    OP_TICK:
                    begin
                        state_next = (status.running && status.tick_data) ? ST_TICK : ST_IDLE;
                    end
                    default:        state_next = ST_IDLE;
                endcase
            end
            ST_RMW:  state_next = ST_IDLE;
            ST_TICK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            clear_reply_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_reply_reg <= clear_reply_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd = '{in_ready: 1'b0, sweep_write: 1'b0, pix_read: 1'b0, pix_write: 1'b0,
                tick_read: 1'b0, start_refresh: 1'b0, emit: EMIT_NONE};
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_last && clear_reply_reg)
                begin
                    cmd.emit = EMIT_PLAIN;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = status.out_empty;
            end
            ST_EXEC:
            begin
                unique case (status.op)
                    OP_WRITE_PIXEL:
                    begin
                        if (status.pixel_in_range)
                        begin
                            cmd.pix_read = 1'b1;
                        end
                        else
                        begin
                            cmd.emit = EMIT_PLAIN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.emit = EMIT_NONE;
                    end
                    OP_START:
                    begin
                        cmd.start_refresh = 1'b1;
                        cmd.emit          = EMIT_PLAIN;
                    end
                    OP_TICK:
                    begin
                        if (!status.running)
                        begin
                            cmd.emit = EMIT_PLAIN;
                        end
                        else if (status.tick_data)
                        begin
                            cmd.tick_read = 1'b1;
                        end
                        else
                        begin
                            cmd.emit = EMIT_TICK;
                        end
                    end
                    default:
                    begin
                        cmd.emit = EMIT_PLAIN;
                    end
                endcase
            end
            ST_RMW:
            begin
                cmd.pix_write = 1'b1;
                cmd.emit      = EMIT_PLAIN;
            end
            ST_TICK:
            begin
                cmd.emit = EMIT_TICK;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

    // an item is decoded only right after it was taken in
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> $past(in_valid && cmd.in_ready))
        else $error("decode without an accepted item");

    // a result is loaded only into an empty output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit != EMIT_NONE |-> status.out_empty)
        else $error("result loaded over a pending result");

    // the store is never read while the clearing sweep writes it
    a_sweep_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_write |-> !cmd.pix_read && !cmd.tick_read && !cmd.pix_write)
        else $error("store access during clearing sweep");

endmodule

// ===== hdl/lcd_framebuffer_refresh_top.sv =====
// lcd_framebuffer_refresh_top: top level of the lcd frame buffer refresh block
// depends on lfr_pkg, lfr_in_if, lfr_out_if, lfr_ctrl, lfr_datapath, lfr_ram
//
// Usage
//   request carries one item: write pixel, clear store, start refresh or tick.
//   result returns exactly one item per request item, in order. A tick during a
//   refresh returns the next panel byte (page command, column high, column low,
//   then the page's column bytes); every other item returns a status item.
//   cfg_write_en/cfg_write_data set the column offset (reset value 4); write it
//   only while no item is in flight.
// Item flow
//   one item at a time through the controller: start refresh, command-byte
//   ticks and idle ticks load their result straight from the decode state,
//   data-byte ticks and in-range pixel writes after one frame store read, clear
//   after the sweep over all PAGE_COUNT*STORE_COLUMNS entries (one store entry
//   written per cycle). The next item is taken once the result has left the
//   output register.
// Reset
//   rst_n clears control state, then a clearing pass zeroes the frame store
//   (PAGE_COUNT*STORE_COLUMNS entries, 1056 by default); request.ready stays low
//   until it ends. Configuration writes are taken during it.
// Stall
//   a result held by result.ready low keeps request.ready low.

module lcd_framebuffer_refresh_top #(
    parameter int PAGE_COUNT    = lfr_pkg::PAGE_COUNT_DEF,
    parameter int STORE_COLUMNS = lfr_pkg::STORE_COLUMNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [lfr_pkg::OFFSET_W-1:0] cfg_write_data,
    lfr_in_if.sink                       request,
    lfr_out_if.source                    result
);

    import lfr_pkg::*;

    lfr_cmd_t    cmd;
    lfr_status_t status;

    // controller
    lfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .status   (status),
        .cmd      (cmd)
    );

    assign request.ready = cmd.in_ready;

    // datapath with frame store
    lfr_datapath #(
        .PAGE_COUNT    (PAGE_COUNT),
        .STORE_COLUMNS (STORE_COLUMNS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (request.valid),
        .in_operation      (request.operation),
        .in_row            (request.row),
        .in_column         (request.column),
        .in_pixel_value    (request.pixel_value),
        .out_ready         (result.ready),
        .out_valid         (result.valid),
        .out_byte_valid    (result.byte_valid),
        .out_serial_byte   (result.serial_byte),
        .out_data_mode     (result.data_mode),
        .out_select_active (result.select_active),
        .out_refresh_done  (result.refresh_done),
        .out_busy_res      (result.busy_res),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
